FILE: hw/rtl/kmm_pkg.sv
`default_nettype none
package kmm_pkg;

  localparam int RAS_W   = 16;
  localparam int ELM_W   = 20;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 37;
  localparam int IDX_W   = 5;
  localparam int KIND_W  = 2;
  localparam int SIZE_W  = 6;

  typedef logic signed [RAS_W-1:0] ras_t;
  typedef logic signed [ELM_W-1:0] elm_t;
  typedef logic [VAL_W-1:0]        val_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [KIND_W-1:0]       kind_t;

  localparam kind_t KIND_WR_A = 2'd0;
  localparam kind_t KIND_WR_B = 2'd1;
  localparam kind_t KIND_CMP  = 2'd2;

  localparam logic REG_SIZE_A = 1'b0;
  localparam logic REG_SIZE_B = 1'b1;

  localparam ras_t RAS_UNSET = '1;
  localparam elm_t ELM_UNSET = '1;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic join_init;
    logic adv_i;
    logic adv_j;
    logic hit;
    logic emit_start;
    logic emit_load;
  } kmm_cmd_t;

  typedef struct packed {
    logic i_end;
    logic j_end;
    logic key_eq;
    logic key_lt;
    logic emit_end;
    logic emit_last;
    logic out_free;
  } kmm_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/kmm_ctrl.sv
`default_nettype none
module kmm_ctrl
  import kmm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire kind_t    in_kind,
  output logic          in_stall,
  input  wire kmm_sts_t sts,
  output kmm_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_JOIN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_WR_A) begin
            cmd.wr_a = 1'b1;
          end else if (in_kind == KIND_WR_B) begin
            cmd.wr_b = 1'b1;
          end else if (in_kind == KIND_CMP) begin
            cmd.join_init = 1'b1;
            state_nxt     = ST_JOIN;
          end
        end
      end
      ST_JOIN: begin
        priority if (sts.i_end) begin
          cmd.emit_start = 1'b1;
          state_nxt      = ST_EMIT;
        end else if (sts.j_end) begin
          cmd.adv_i = 1'b1;
        end else if (sts.key_eq) begin
          cmd.hit = 1'b1;
        end else if (sts.key_lt) begin
          cmd.adv_i = 1'b1;
        end else begin
          cmd.adv_j = 1'b1;
        end
      end
      ST_EMIT: begin
        priority if (sts.emit_end) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/kmm_dp.sv
`default_nettype none
module kmm_dp
  import kmm_pkg::*;
#(
  parameter int LIST_DEPTH = 32
)(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kmm_cmd_t          cmd,
  output kmm_sts_t               sts,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire ras_t              in_raster_id,
  input  wire elm_t              in_elem_id,
  input  wire val_t              in_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_list_sel,
  output logic [IDX_W-1:0]       out_index,
  output ras_t                   out_raster,
  output elm_t                   out_elem,
  output val_t                   out_value,
  output sum_t                   out_running_sum,
  output logic                   out_last
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  ras_t a_ras_r [LIST_DEPTH];
  elm_t a_elm_r [LIST_DEPTH];
  val_t a_val_r [LIST_DEPTH];
  ras_t b_ras_r [LIST_DEPTH];
  elm_t b_elm_r [LIST_DEPTH];
  val_t b_val_r [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] a_vld_r;
  logic [LIST_DEPTH-1:0] b_vld_r;

  logic [CW-1:0] na_r, nb_r, size_clamp;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, res_r, res_nxt;
  logic          sel_r, sel_nxt;
  sum_t          sum_r, sum_nxt, cur_sum;
  logic          out_valid_r, out_valid_nxt;

  logic          out_sel_r, out_last_r;
  logic [IDX_W-1:0] out_idx_r;
  ras_t          out_ras_r;
  elm_t          out_elm_r;
  val_t          out_val_r;
  sum_t          out_sum_r;

  logic [IW-1:0] i_addr, j_addr, w_addr;
  logic          a_wr_ok, b_wr_ok, a_wins;
  ras_t          a_rd_ras, b_rd_ras, e_ras;
  elm_t          a_rd_elm, b_rd_elm, e_elm;
  val_t          a_rd_val, b_rd_val, e_val;
  logic [CW-1:0] i_inc, j_inc;

  assign i_addr = i_r[IW-1:0];
  assign j_addr = j_r[IW-1:0];
  assign w_addr = in_entry_index[IW-1:0];
  assign i_inc  = CW'(i_r + 1'b1);
  assign j_inc  = CW'(j_r + 1'b1);

  assign size_clamp = (cfg_wdata > SIZE_W'(LIST_DEPTH)) ? CW'(LIST_DEPTH) : CW'(cfg_wdata);
  assign a_wr_ok = cmd.wr_a && ({1'b0, in_entry_index} < SIZE_W'(na_r));
  assign b_wr_ok = cmd.wr_b && ({1'b0, in_entry_index} < SIZE_W'(nb_r));

  // unset entries read as the cleared value
  assign a_rd_ras = a_vld_r[i_addr] ? a_ras_r[i_addr] : RAS_UNSET;
  assign a_rd_elm = a_vld_r[i_addr] ? a_elm_r[i_addr] : ELM_UNSET;
  assign a_rd_val = a_vld_r[i_addr] ? a_val_r[i_addr] : '0;
  assign b_rd_ras = b_vld_r[j_addr] ? b_ras_r[j_addr] : RAS_UNSET;
  assign b_rd_elm = b_vld_r[j_addr] ? b_elm_r[j_addr] : ELM_UNSET;
  assign b_rd_val = b_vld_r[j_addr] ? b_val_r[j_addr] : '0;

  assign a_wins = (a_rd_val >= b_rd_val);

  assign sts.i_end     = (i_r >= na_r);
  assign sts.j_end     = (j_r >= nb_r);
  assign sts.key_eq    = (a_rd_ras == b_rd_ras) && (a_rd_elm == b_rd_elm);
  assign sts.key_lt    = (a_rd_ras < b_rd_ras) ||
                         ((a_rd_ras == b_rd_ras) && (a_rd_elm < b_rd_elm));
  assign sts.emit_end  = sel_r && (j_r >= nb_r);
  assign sts.emit_last = sel_r ? (j_inc == nb_r) : ((i_inc == na_r) && (nb_r == '0));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign e_ras   = sel_r ? b_rd_ras : a_rd_ras;
  assign e_elm   = sel_r ? b_rd_elm : a_rd_elm;
  assign e_val   = sel_r ? b_rd_val : a_rd_val;
  assign cur_sum = sum_r + SUM_W'(e_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      b_vld_r <= '0;
      na_r    <= '0;
      nb_r    <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_SIZE_A)) begin
        na_r    <= size_clamp;
        a_vld_r <= '0;
      end else if (a_wr_ok) begin
        a_vld_r[w_addr] <= 1'b1;
      end
      if (cfg_we && (cfg_index == REG_SIZE_B)) begin
        nb_r    <= size_clamp;
        b_vld_r <= '0;
      end else if (b_wr_ok) begin
        b_vld_r[w_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_wr_ok) begin
      a_ras_r[w_addr] <= in_raster_id;
      a_elm_r[w_addr] <= in_elem_id;
      a_val_r[w_addr] <= in_value;
    end else if (cmd.hit && !a_wins) begin
      a_val_r[i_addr] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_wr_ok) begin
      b_ras_r[w_addr] <= in_raster_id;
      b_elm_r[w_addr] <= in_elem_id;
      b_val_r[w_addr] <= in_value;
    end else if (cmd.hit && a_wins) begin
      b_val_r[j_addr] <= '0;
    end
  end

  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    res_nxt = res_r;
    sel_nxt = sel_r;
    sum_nxt = sum_r;
    if (cmd.join_init) begin
      i_nxt   = '0;
      j_nxt   = '0;
      res_nxt = '0;
    end
    if (cmd.adv_i) begin
      i_nxt = i_inc;
      j_nxt = res_r;
    end
    if (cmd.adv_j) begin
      j_nxt = j_inc;
    end
    if (cmd.hit) begin
      i_nxt   = i_inc;
      res_nxt = j_r;
    end
    if (cmd.emit_start) begin
      i_nxt   = '0;
      j_nxt   = '0;
      sel_nxt = (na_r == '0);
      sum_nxt = '0;
    end
    if (cmd.emit_load) begin
      if (sel_r) begin
        j_nxt   = j_inc;
        sum_nxt = cur_sum;
      end else if (i_inc == na_r) begin
        sel_nxt = 1'b1;
        sum_nxt = '0;
      end else begin
        i_nxt   = i_inc;
        sum_nxt = cur_sum;
      end
    end
  end

  assign out_valid_nxt = cmd.emit_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      res_r       <= '0;
      sel_r       <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      res_r       <= res_nxt;
      sel_r       <= sel_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_sel_r  <= sel_r;
      out_idx_r  <= IDX_W'(sel_r ? j_r : i_r);
      out_ras_r  <= e_ras;
      out_elm_r  <= e_elm;
      out_val_r  <= e_val;
      out_sum_r  <= cur_sum;
      out_last_r <= sts.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_list_sel    = out_sel_r;
  assign out_index       = out_idx_r;
  assign out_raster      = out_ras_r;
  assign out_elem        = out_elm_r;
  assign out_value       = out_val_r;
  assign out_running_sum = out_sum_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/keyed_list_merge_max_masker_top.sv
// keyed list merge max masker
// input channel (in_valid / in_stall) takes one beat per item: kind 0 or 1
// writes an entry of list a or b at in_entry_index (dropped when not below
// that list's size), kind 2 runs the merge join and emits, kind 3 is dropped.
// config channel (cfg_valid / cfg_ready, always ready) writes size_a (index
// 0) or size_b (index 1); a size write also clears that list to unset entries.
// a write item does not stall the input. a compare item runs the join one step per
// cycle over the shared compare unit, then, while out_stall is low, emits one
// result beat per cycle, size_a + size_b beats in all, out_last on the final one.
// while a compare runs, in_stall is high; the input is taken again as soon as
// the last beat sits in the output register.
// when the receiver raises out_stall the output register holds its beat and
// emission pauses until it is taken.
// rst_n (synchronous) sets both sizes to zero and all entries to unset.
`default_nettype none
module keyed_list_merge_max_masker_top
  import kmm_pkg::*;
#(
  parameter int LIST_DEPTH = 32
)(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire kind_t             in_kind,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire ras_t              in_raster_id,
  input  wire elm_t              in_elem_id,
  input  wire val_t              in_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_list_sel,
  output logic [IDX_W-1:0]       out_index,
  output ras_t                   out_raster,
  output elm_t                   out_elem,
  output val_t                   out_value,
  output sum_t                   out_running_sum,
  output logic                   out_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_wdata
);

  kmm_cmd_t cmd;
  kmm_sts_t sts;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  kmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmm_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_entry_index  (in_entry_index),
    .in_raster_id    (in_raster_id),
    .in_elem_id      (in_elem_id),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_list_sel    (out_list_sel),
    .out_index       (out_index),
    .out_raster      (out_raster),
    .out_elem        (out_elem),
    .out_value       (out_value),
    .out_running_sum (out_running_sum),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit |-> (!sts.i_end && !sts.j_end))
    else $error("join hit outside list bounds");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |=> out_valid)
    else $error("emitted beat not presented");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall && !cmd.emit_load) |=> !out_valid)
    else $error("beat after the final beat of a run");

  a_cmp_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == KIND_CMP)) |=> in_stall)
    else $error("input taken while compare runs");
`endif

endmodule
`default_nettype wire
